// File: hdl/i2c_register_file_target_unit_defines.svh
// Assertion macros used by the register file target controller RTL.
`ifndef I2C_REGISTER_FILE_TARGET_UNIT_DEFINES_SVH
`define I2C_REGISTER_FILE_TARGET_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define I2CRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define I2CRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CRF_ASSERT(label, clk, rst, prop, msg)
`define I2CRF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: hdl/i2crf_pkg.sv
// Package with types, codes and command structs of the register file target.
`timescale 1ns / 1ps
`default_nettype none

package i2crf_pkg;

   localparam int POINTER_BITS = 16;
   localparam int STORE_DEPTH  = 1 << POINTER_BITS;

   typedef logic [1:0]              op_type;
   typedef logic [1:0]              action_type;
   typedef logic [1:0]              count_type;
   typedef logic [7:0]              byte_type;
   typedef logic [POINTER_BITS-1:0] ptr_type;

   localparam op_type OP_START_WRITE = 2'd0;
   localparam op_type OP_OTHER_EVENT = 2'd1;
   localparam op_type OP_WRITE_BYTE  = 2'd2;
   localparam op_type OP_READ_BYTE   = 2'd3;

   localparam action_type ACT_EVENT   = 2'd0;
   localparam action_type ACT_ADDRESS = 2'd1;
   localparam action_type ACT_STORED  = 2'd2;
   localparam action_type ACT_READ    = 2'd3;

   localparam count_type ADDR_COUNT_RESET = 2'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic read_cap;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic req_is_read;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/i2crf_req_if.sv
// Request channel interface: bus operation and written byte.
`timescale 1ns / 1ps
`default_nettype none

interface i2crf_req_if;
   import i2crf_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   byte_type data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/i2crf_rsp_if.sv
// Response channel interface: read byte and byte action.
`timescale 1ns / 1ps
`default_nettype none

interface i2crf_rsp_if;
   import i2crf_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   read_data;
   action_type byte_action;

   modport source (output valid, output read_data, output byte_action, input ready);
   modport sink   (input valid, input read_data, input byte_action, output ready);
endinterface

`default_nettype wire

// File: hdl/i2crf_dpath.sv
// Datapath: register store, pointer, address byte counter and response payload.
`timescale 1ns / 1ps
`default_nettype none

module i2crf_dpath (
   input  wire                     clock,
   input  wire                     reset,
   input  i2crf_pkg::dp_cmd_type   cmd,
   output i2crf_pkg::dp_status_type status,
   input  i2crf_pkg::op_type       req_operation,
   input  i2crf_pkg::byte_type     req_data_byte,
   input  wire                     csr_wr_en,
   input  i2crf_pkg::count_type    csr_wr_data,
   output i2crf_pkg::byte_type     rsp_read_data,
   output i2crf_pkg::action_type   rsp_byte_action
);
   import i2crf_pkg::*;

   byte_type   store_mem [STORE_DEPTH];
   byte_type   mem_q_ff;

   ptr_type    clear_addr_ff, clear_addr_in;
   ptr_type    ptr_ff, ptr_in;
   count_type  seen_ff, seen_in;
   count_type  count_ff, count_in;
   byte_type   rdata_ff, rdata_in;
   action_type action_ff, action_in;

   logic       addr_phase;
   logic       mem_we;
   ptr_type    mem_waddr;
   byte_type   mem_wdata;
   logic [POINTER_BITS+7:0] shifted;

   assign addr_phase = seen_ff < count_ff;
   assign shifted    = {ptr_ff, req_data_byte};

   always_comb begin
      ptr_in        = ptr_ff;
      seen_in       = seen_ff;
      rdata_in      = rdata_ff;
      action_in     = action_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = req_data_byte;
      clear_addr_in = clear_addr_ff;
      count_in      = csr_wr_en ? csr_wr_data : count_ff;

      if (cmd.clear_wr) begin
         mem_we        = 1'b1;
         mem_waddr     = clear_addr_ff;
         mem_wdata     = '0;
         clear_addr_in = clear_addr_ff + 1'b1;
      end

      if (cmd.accept) begin
         rdata_in  = '0;
         action_in = ACT_EVENT;
         unique case (req_operation)
            OP_START_WRITE: begin
               seen_in = '0;
            end
            OP_OTHER_EVENT: begin
               seen_in = seen_ff;
            end
            OP_WRITE_BYTE: begin
               if (addr_phase) begin
                  if (count_ff == 2'd1) begin
                     ptr_in = ptr_type'(req_data_byte);
                  end else begin
                     ptr_in = shifted[POINTER_BITS-1:0];
                  end
                  seen_in   = seen_ff + 1'b1;
                  action_in = ACT_ADDRESS;
               end else begin
                  mem_we    = 1'b1;
                  ptr_in    = ptr_ff + 1'b1;
                  action_in = ACT_STORED;
               end
            end
            OP_READ_BYTE: begin
               // Data arrives in the next cycle through the registered read port.
               ptr_in = ptr_ff + 1'b1;
            end
            default: begin
               seen_in = seen_ff;
            end
         endcase
      end

      if (cmd.read_cap) begin
         rdata_in  = mem_q_ff;
         action_in = ACT_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= store_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         ptr_ff        <= '0;
         seen_ff       <= '0;
         count_ff      <= ADDR_COUNT_RESET;
      end else begin
         clear_addr_ff <= clear_addr_in;
         ptr_ff        <= ptr_in;
         seen_ff       <= seen_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= rdata_in;
      action_ff <= action_in;
   end

   assign status.clear_last  = &clear_addr_ff;
   assign status.req_is_read = (req_operation == OP_READ_BYTE);
   assign rsp_read_data      = rdata_ff;
   assign rsp_byte_action    = action_ff;

endmodule

`default_nettype wire

// File: hdl/i2crf_ctrl.sv
// Controller: clearing sweep, request acceptance, read sequencing, response valid.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_file_target_unit_defines.svh"

module i2crf_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output i2crf_pkg::dp_cmd_type    cmd,
   input  i2crf_pkg::dp_status_type status
);
   import i2crf_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_ready && req_valid;

   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.accept   = accept;
   assign cmd.read_cap = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (status.req_is_read) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `I2CRF_ASSERT(a_no_accept_in_clear, clock, reset, (state_ff == ST_CLEAR) |-> !rsp_valid_ff && !accept, "item or response during clearing sweep")
   `I2CRF_ASSERT(a_read_goes_to_read, clock, reset, (accept && status.req_is_read) |=> (state_ff == ST_READ), "read accept did not enter read state")
   `I2CRF_ASSERT(a_read_gives_rsp, clock, reset, (state_ff == ST_READ) |=> rsp_valid_ff && (state_ff == ST_IDLE), "read state did not post a response")
   `I2CRF_ASSERT(a_write_gives_rsp, clock, reset, (accept && !status.req_is_read) |=> rsp_valid_ff, "non-read accept did not post a response")

endmodule

`default_nettype wire

// File: hdl/i2c_register_file_target_unit.sv
// Top level of the byte-level I2C register file target with auto-increment pointer.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Beat contents                  Handshake
// req_chan    in         operation, data_byte           valid/ready
// rsp_chan    out        read_data, byte_action         valid/ready
// csr_wr_*    in         address_byte_count (2 bits)    write enable, no wait
//
// After reset the 65536-byte register store is cleared, one byte per cycle, so
// req_chan.ready stays low until the sweep ends; csr writes are taken during it.
// For an event, pointer byte or data store the response beat is valid the cycle
// after acceptance. A read passes through the read state, which captures the data
// from the registered read port of the store. One item is in work at a time; the
// next request beat is taken in the same cycle that the pending response beat
// leaves, so a stalled rsp_chan holds off req_chan.

module i2c_register_file_target_unit (
   input  wire                  clock,
   input  wire                  reset,
   i2crf_req_if.sink            req_chan,
   i2crf_rsp_if.source          rsp_chan,
   input  wire                  csr_wr_en,
   input  i2crf_pkg::count_type csr_wr_data
);
   import i2crf_pkg::*;

   // Command and status between the controller and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller owns sequencing: the clearing sweep, the accept decision,
   // the read state that captures read data and the response valid flag.
   i2crf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the store, the register pointer, the count of pointer
   // bytes seen in this write transfer, the configured count and the response payload.
   i2crf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_chan.operation),
      .req_data_byte   (req_chan.data_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_byte_action (rsp_chan.byte_action)
   );

endmodule

`default_nettype wire
